/* rtl/core/lrps_pkg.sv */
`default_nettype none

package lrps_pkg;

  localparam int unsigned RING_W = 5;
  localparam int unsigned MODE_W = 5;
  localparam logic [MODE_W-1:0] LAST_MODE = 5'd24;

  localparam logic [RING_W-1:0] RING_MASK = 5'h1F;
  localparam logic [7:0]        DIR_BIT   = 8'h80;

  // operation codes of an input item
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_NEXT = 2'd1;
  localparam logic [1:0] OP_PREV = 2'd2;

  typedef enum logic [3:0] {
    FN_RANDOM     = 4'd0,
    FN_ROT_L      = 4'd1,
    FN_ROT_R      = 4'd2,
    FN_BOUNCE_LIT = 4'd3,
    FN_BOUNCE_DRK = 4'd4,
    FN_CTR_OUT    = 4'd5,
    FN_CTR_IN     = 4'd6,
    FN_BLINK      = 4'd7,
    FN_CNT_UP     = 4'd8,
    FN_CNT_DOWN   = 4'd9
  } pat_fn_t;

  // animation function of each mode
  function automatic pat_fn_t mode_fn(input logic [MODE_W-1:0] idx);
    pat_fn_t f;
    case (idx) inside
      5'd0:                               f = FN_RANDOM;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5:       f = FN_ROT_L;
      5'd6, 5'd7, 5'd8:                   f = FN_ROT_R;
      5'd9, 5'd10, 5'd11, 5'd12:          f = FN_BOUNCE_LIT;
      5'd13, 5'd14, 5'd15, 5'd16:         f = FN_BOUNCE_DRK;
      5'd17, 5'd18, 5'd19:                f = FN_CTR_OUT;
      5'd20, 5'd21:                       f = FN_CTR_IN;
      5'd22:                              f = FN_BLINK;
      5'd23:                              f = FN_CNT_UP;
      default:                            f = FN_CNT_DOWN;
    endcase
    return f;
  endfunction

  // start entry of each mode: low five bits pattern, bit 7 heads right
  function automatic logic [7:0] mode_start(input logic [MODE_W-1:0] idx);
    logic [7:0] e;
    case (idx)
      5'd0:    e = 8'h01;
      5'd1:    e = 8'h01;
      5'd2:    e = 8'h03;
      5'd3:    e = 8'h07;
      5'd4:    e = 8'h0F;
      5'd5:    e = 8'h1E;
      5'd6:    e = 8'h1C;
      5'd7:    e = 8'h18;
      5'd8:    e = 8'h10;
      5'd9:    e = 8'h10;
      5'd10:   e = 8'h18;
      5'd11:   e = 8'h1C;
      5'd12:   e = 8'h1E;
      5'd13:   e = 8'h9E;
      5'd14:   e = 8'h9C;
      5'd15:   e = 8'h98;
      5'd16:   e = 8'h90;
      5'd17:   e = 8'h04;
      5'd18:   e = 8'h0E;
      5'd19:   e = 8'h1F;
      5'd20:   e = 8'h0E;
      5'd21:   e = 8'h04;
      5'd22:   e = 8'h00;
      5'd23:   e = 8'h00;
      default: e = 8'h1F;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lrps_in_if.sv */
`default_nettype none

interface lrps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] random_byte;

  modport source (output valid, output opcode, output random_byte, input ready);
  modport sink   (input valid, input opcode, input random_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/lrps_out_if.sv */
`default_nettype none

interface lrps_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] led_pattern;
  logic [4:0] mode_number;

  modport source (output valid, output led_pattern, output mode_number, input ready);
  modport sink   (input valid, input led_pattern, input mode_number, output ready);
endinterface

`default_nettype wire

/* rtl/core/led_ring_pattern_sequencer.sv */
`default_nettype none

// five-LED ring animator with 25 fixed modes. each input item is a tick, a next-mode or a
// previous-mode command and yields exactly one output item carrying the ring pattern and the
// mode index after the command. one item is taken per clock while the output register is empty
// or being drained in that same cycle: the next pattern is a few gates of shift, mask and add
// logic on the five-bit state, written straight into the state registers and the output register
// in the cycle of acceptance, so a result appears in the cycle after its item. random mode copies
// the low five bits of random_byte; opcode 3 is a no-op that reports the current state
module led_ring_pattern_sequencer (
  input  wire logic clk,
  input  wire logic rst_n,
  lrps_in_if.sink   in_chan,
  lrps_out_if.source out_chan
);
  import lrps_pkg::*;

  // animation state
  logic [MODE_W-1:0] mode_index_r, mode_index_nxt;
  logic [RING_W-1:0] pattern_r, pattern_nxt;
  logic              heading_r, heading_nxt;

  // output register
  logic              out_valid_r;
  logic [RING_W-1:0] out_pattern_r;
  logic [MODE_W-1:0] out_mode_r;

  logic        accept;
  logic [MODE_W-1:0] mode_sel;
  logic [7:0]  start_e;
  logic [2:0]  ctr;

  // the output register frees up in the same cycle it is drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // mode being loaded on a mode change
  always_comb begin
    mode_sel = mode_index_r;
    if (in_chan.opcode == OP_NEXT) begin
      mode_sel = (mode_index_r == LAST_MODE) ? '0 : mode_index_r + 5'd1;
    end else if (in_chan.opcode == OP_PREV) begin
      mode_sel = (mode_index_r == '0) ? LAST_MODE : mode_index_r - 5'd1;
    end
  end

  assign start_e = mode_start(mode_sel);

  always_comb begin
    mode_index_nxt = mode_index_r;
    pattern_nxt    = pattern_r;
    heading_nxt    = heading_r;
    ctr            = pattern_r[2:0];
    case (in_chan.opcode) inside
      OP_TICK: begin
        case (mode_fn(mode_index_r))
          FN_RANDOM: pattern_nxt = in_chan.random_byte[RING_W-1:0];
          FN_ROT_L:  pattern_nxt = {pattern_r[3:0], pattern_r[4]};
          FN_ROT_R:  pattern_nxt = {pattern_r[0], pattern_r[4:1]};
          FN_BOUNCE_LIT: begin
            // a lit led walks to the end of the ring and turns around
            if (heading_r) begin
              if (pattern_r[0]) begin
                heading_nxt = 1'b0;
                pattern_nxt = {pattern_r[3:0], 1'b0};
              end else begin
                pattern_nxt = {1'b0, pattern_r[4:1]};
              end
            end else begin
              if (pattern_r[4]) begin
                heading_nxt = 1'b1;
                pattern_nxt = {1'b0, pattern_r[4:1]};
              end else begin
                pattern_nxt = {pattern_r[3:0], 1'b0};
              end
            end
          end
          FN_BOUNCE_DRK: begin
            // same walk with a dark led, shifting in ones
            if (heading_r) begin
              if (!pattern_r[0]) begin
                heading_nxt = 1'b0;
                pattern_nxt = {pattern_r[3:0], 1'b1};
              end else begin
                pattern_nxt = {1'b1, pattern_r[4:1]};
              end
            end else begin
              if (!pattern_r[4]) begin
                heading_nxt = 1'b1;
                pattern_nxt = {1'b1, pattern_r[4:1]};
              end else begin
                pattern_nxt = {pattern_r[3:0], 1'b1};
              end
            end
          end
          FN_CTR_OUT: begin
            // three-led cycle on the low three leds, its low two bits copied onto the top two leds
            ctr         = {pattern_r[0], pattern_r[2:1]};
            pattern_nxt = {ctr[1], ctr[0], ctr};
          end
          FN_CTR_IN: begin
            ctr         = {pattern_r[1:0], pattern_r[2]};
            pattern_nxt = {ctr[1], ctr[0], ctr};
          end
          FN_BLINK:  pattern_nxt = pattern_r ^ RING_MASK;
          FN_CNT_UP: pattern_nxt = pattern_r + 5'd1;
          default:   pattern_nxt = pattern_r - 5'd1;
        endcase
      end
      OP_NEXT, OP_PREV: begin
        mode_index_nxt = mode_sel;
        pattern_nxt    = start_e[RING_W-1:0];
        heading_nxt    = |(start_e & DIR_BIT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_index_r <= '0;
      pattern_r    <= 5'd1;
      heading_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        mode_index_r <= mode_index_nxt;
        pattern_r    <= pattern_nxt;
        heading_r    <= heading_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pattern_r <= pattern_nxt;
      out_mode_r    <= mode_index_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.led_pattern = out_pattern_r;
  assign out_chan.mode_number = out_mode_r;

endmodule

`default_nettype wire
